[src/phs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phs_pkg
// Shared types, codes and helpers for the phase sequencer with settle detect.
// ----------------------------------------------------------------------------
package phs_pkg;

   // action codes carried in req_tuser
   localparam logic [2:0] ACT_START  = 3'd0;
   localparam logic [2:0] ACT_HOLD   = 3'd1;
   localparam logic [2:0] ACT_STOP   = 3'd2;
   localparam logic [2:0] ACT_RESUME = 3'd3;
   localparam logic [2:0] ACT_RESET  = 3'd4;
   localparam logic [2:0] ACT_UPDATE = 3'd5;

   // configuration register indexes
   localparam logic REG_SAMPLING_TICKS   = 1'b0;
   localparam logic REG_SETTLE_THRESHOLD = 1'b1;

   // reset values of the configuration registers
   localparam logic [15:0] SAMPLING_TICKS_RST   = 16'd1000;
   localparam logic [15:0] SETTLE_THRESHOLD_RST = 16'd100;

   // output phase codes
   localparam logic [3:0] CODE_IDLE      = 4'd0;
   localparam logic [3:0] CODE_EXEC      = 4'd1;
   localparam logic [3:0] CODE_HOLDING   = 4'd2;
   localparam logic [3:0] CODE_HELD      = 4'd3;
   localparam logic [3:0] CODE_RESUMING  = 4'd4;
   localparam logic [3:0] CODE_STOPPING  = 4'd5;
   localparam logic [3:0] CODE_STOPPED   = 4'd6;
   localparam logic [3:0] CODE_COMPLETE  = 4'd7;
   localparam logic [3:0] CODE_RESETTING = 4'd8;

   // output step codes
   localparam logic [1:0] CODE_STEP_START  = 2'd0;
   localparam logic [1:0] CODE_STEP_SETTLE = 2'd1;
   localparam logic [1:0] CODE_STEP_STOP   = 2'd2;

   localparam logic [15:0] TICK_MAX = 16'hFFFF;

   typedef enum logic [8:0] {
      PH_IDLE      = 9'b000000001,
      PH_EXEC      = 9'b000000010,
      PH_HOLDING   = 9'b000000100,
      PH_HELD      = 9'b000001000,
      PH_RESUMING  = 9'b000010000,
      PH_STOPPING  = 9'b000100000,
      PH_STOPPED   = 9'b001000000,
      PH_COMPLETE  = 9'b010000000,
      PH_RESETTING = 9'b100000000
   } phase_type;

   typedef enum logic [2:0] {
      STEP_START  = 3'b001,
      STEP_SETTLE = 3'b010,
      STEP_STOP   = 3'b100
   } step_type;

   // one input item as held in the input register
   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] pressure_sample;
      logic        motor_is_on;
   } item_type;

   function automatic logic [3:0] phase_code(input phase_type ph);
      logic [3:0] code;
      case (ph)
         PH_IDLE:      code = CODE_IDLE;
         PH_EXEC:      code = CODE_EXEC;
         PH_HOLDING:   code = CODE_HOLDING;
         PH_HELD:      code = CODE_HELD;
         PH_RESUMING:  code = CODE_RESUMING;
         PH_STOPPING:  code = CODE_STOPPING;
         PH_STOPPED:   code = CODE_STOPPED;
         PH_COMPLETE:  code = CODE_COMPLETE;
         PH_RESETTING: code = CODE_RESETTING;
         default:      code = CODE_IDLE;
      endcase
      return code;
   endfunction

   function automatic logic [1:0] step_code(input step_type st);
      logic [1:0] code;
      case (st)
         STEP_START:  code = CODE_STEP_START;
         STEP_SETTLE: code = CODE_STEP_SETTLE;
         STEP_STOP:   code = CODE_STEP_STOP;
         default:     code = CODE_STEP_START;
      endcase
      return code;
   endfunction

endpackage

[src/phs_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phs_in_stage
// Input register: captures one request transfer and holds it until the
// sequencer engine takes it.
// ----------------------------------------------------------------------------
module phs_in_stage
   import phs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] pressure_sample, [16] motor_is_on, rest zero
   input  logic [2:0]  req_tuser,   // [2:0] action
   input  logic        take,
   output logic        item_valid,
   output item_type    item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   // free when empty or when the held item moves on this cycle
   assign req_tready = !valid_ff || take;

   // next contents of the input register
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         if (req_tvalid) begin
            item_in.action          = req_tuser;
            item_in.pressure_sample = req_tdata[15:0];
            item_in.motor_is_on     = req_tdata[16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[src/phs_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phs_engine
// Phase state machine, execution steps, settle timer and result register.
// ----------------------------------------------------------------------------
module phs_engine
   import phs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   input  logic        item_valid,
   input  item_type    item,
   output logic        take,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // [3:0] phase, [5:4] exec_step, [6] motor_request, [7] zero
);

   logic [15:0] sampling_ticks_ff, sampling_ticks_in;
   logic [15:0] settle_threshold_ff, settle_threshold_in;

   phase_type   phase_ff, phase_in;
   step_type    step_ff, step_in;
   logic [15:0] tick_ff, tick_in;
   logic        timer_ff, timer_in;
   logic [15:0] held_ff, held_in;
   logic        motor_ff, motor_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;

   logic [15:0] tick_inc;
   logic [15:0] diff;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      sampling_ticks_in   = sampling_ticks_ff;
      settle_threshold_in = settle_threshold_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SAMPLING_TICKS:   sampling_ticks_in   = csr_data;
            REG_SETTLE_THRESHOLD: settle_threshold_in = csr_data;
            default: ;
         endcase
      end
   end

   // the held item moves on when the result register is free
   assign take = item_valid && (!rsp_valid_ff || rsp_tready);

   // saturating tick count and absolute sample difference
   assign tick_inc = (timer_ff && tick_ff != TICK_MAX) ? tick_ff + 16'd1 : tick_ff;
   assign diff     = (item.pressure_sample >= held_ff) ? item.pressure_sample - held_ff
                                                       : held_ff - item.pressure_sample;

   // sequencer next state
   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      tick_in  = tick_ff;
      timer_in = timer_ff;
      held_in  = held_ff;
      motor_in = motor_ff;
      if (take) begin
         case (item.action)
            ACT_START: begin
               if (phase_ff == PH_IDLE) phase_in = PH_EXEC;
            end
            ACT_HOLD: begin
               if (phase_ff == PH_EXEC) phase_in = PH_HOLDING;
            end
            ACT_STOP: begin
               if (phase_ff inside {PH_EXEC, PH_RESUMING, PH_HOLDING, PH_HELD})
                  phase_in = PH_STOPPING;
            end
            ACT_RESUME: begin
               if (phase_ff == PH_HELD) phase_in = PH_RESUMING;
            end
            ACT_RESET: begin
               if (phase_ff inside {PH_STOPPED, PH_COMPLETE}) phase_in = PH_RESETTING;
            end
            ACT_UPDATE: begin
               tick_in = tick_inc;
               case (phase_ff)
                  PH_EXEC: begin
                     case (step_ff)
                        STEP_START: begin
                           motor_in = 1'b1;
                           if (item.motor_is_on) begin
                              held_in  = item.pressure_sample;
                              tick_in  = '0;
                              timer_in = 1'b1;
                              step_in  = STEP_SETTLE;
                           end
                        end
                        STEP_SETTLE: begin
                           if (tick_inc > sampling_ticks_ff) begin
                              if (diff < settle_threshold_ff) begin
                                 timer_in = 1'b0;
                                 step_in  = STEP_STOP;
                              end else begin
                                 held_in = item.pressure_sample;
                                 tick_in = '0;
                              end
                           end
                        end
                        STEP_STOP: begin
                           motor_in = 1'b0;
                           if (!item.motor_is_on) phase_in = PH_COMPLETE;
                        end
                        default: ;
                     endcase
                  end
                  PH_HOLDING, PH_STOPPING: begin
                     motor_in = 1'b0;
                     if (!item.motor_is_on) begin
                        timer_in = 1'b0;
                        phase_in = (phase_ff == PH_HOLDING) ? PH_HELD : PH_STOPPED;
                     end
                  end
                  PH_RESUMING, PH_RESETTING: begin
                     tick_in  = '0;
                     timer_in = 1'b0;
                     step_in  = STEP_START;
                     phase_in = (phase_ff == PH_RESUMING) ? PH_EXEC : PH_IDLE;
                  end
                  PH_COMPLETE: phase_in = PH_RESETTING;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, motor_in, step_code(step_in), phase_code(phase_in)};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sampling_ticks_ff   <= SAMPLING_TICKS_RST;
         settle_threshold_ff <= SETTLE_THRESHOLD_RST;
         phase_ff            <= PH_IDLE;
         step_ff             <= STEP_START;
         tick_ff             <= '0;
         timer_ff            <= 1'b0;
         held_ff             <= '0;
         motor_ff            <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         sampling_ticks_ff   <= sampling_ticks_in;
         settle_threshold_ff <= settle_threshold_in;
         phase_ff            <= phase_in;
         step_ff             <= step_in;
         tick_ff             <= tick_in;
         timer_ff            <= timer_in;
         held_ff             <= held_in;
         motor_ff            <= motor_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[src/phase_sequencer_with_settle_detect_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_sequencer_with_settle_detect_top
// Batch phase sequencer: commands and update ticks in, phase, execution step
// and agitator command out, one result per request.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_tvalid/tready     tdata: sample, motor fb; tuser: action
//  rsp      out        rsp_tvalid/tready     tdata: phase, exec_step, motor_request
//  csr      in         csr_valid/ready       csr_index, csr_data
//
//  a request is registered on transfer and handled once the result register is
//  free, so its result is registered there and then held until it transfers
//  sustained rate is one request per cycle while rsp_tready stays high, set by
//  the single state update between the input register and the result register
//  reset is synchronous, active high; configuration returns to 1000 / 100
//  a stalled result holds the result register; the input register still
//  takes one more request, then req_tready drops
// ----------------------------------------------------------------------------
module phase_sequencer_with_settle_detect_top
   import phs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] pressure_sample, [16] motor_is_on, rest zero
   input  logic [2:0]  req_tuser,   // [2:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] phase, [5:4] exec_step, [6] motor_request, [7] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic     take;
   logic     item_valid;
   item_type item;

   // input register
   phs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // sequencer and result register
   phs_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a handled item always leaves a result behind
   assert property (@(posedge clock) disable iff (reset) take |=> rsp_tvalid)
      else $error("handled request left no result");

   // step code three never occurs
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:4] != 2'd3)
      else $error("invalid execution step reported");

   // agitator only driven while executing, holding or stopping
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[6]) |->
         (rsp_tdata[3:0] == CODE_EXEC || rsp_tdata[3:0] == CODE_HOLDING ||
          rsp_tdata[3:0] == CODE_STOPPING))
      else $error("motor requested in a quiet phase");

endmodule

[dv/phase_sequencer_with_settle_detect_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_sequencer_with_settle_detect_checker
// Passive monitor for the phase sequencer. It tracks register writes, keeps
// its own copy of the batch phase machine, queues the phase, step and motor
// command expected for each accepted request, and compares every result
// transfer against the oldest of them.
// ----------------------------------------------------------------------------
module phase_sequencer_with_settle_detect_checker
   import phs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] pressure_sample, [16] motor_is_on, rest zero
   input  logic [2:0]  req_tuser,   // [2:0] action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [3:0] phase, [5:4] exec_step, [6] motor_request, [7] zero
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   output int          mismatch_total,
   output int          pending_total,
   output int          result_total,
   output int          settle_total,
   output int          complete_total,
   output int          held_total
);

   // packed to match rsp_tdata[6:0]
   typedef struct packed {
      logic       motor_request;
      logic [1:0] exec_step;
      logic [3:0] phase;
   } phase_result_type;

   // register copies
   logic [15:0] sample_period;
   logic [15:0] settle_band;

   // sequencer copy
   logic [3:0]  seq_phase;
   logic [1:0]  seq_step;
   logic [15:0] tick_count;
   logic        timer_on;
   logic [15:0] held_pressure;
   logic        motor_on;

   phase_result_type expected_q[$];
   int fail_count;
   int rsp_count;
   int settles;
   int completions;
   int holds;

   function automatic void note_failure(input string what, input phase_result_type want,
                                        input phase_result_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t mismatch (%s): expected phase %0d step %0d motor %0b, got phase %0d step %0d motor %0b",
                  $realtime, what, want.phase, want.exec_step, want.motor_request,
                  got.phase, got.exec_step, got.motor_request);
   endfunction

   // one execution step on an update tick
   function automatic void run_step(input logic [15:0] pressure, input logic fb);
      logic [15:0] gap;
      case (seq_step)
         CODE_STEP_START: begin
            motor_on = 1'b1;
            if (fb) begin
               held_pressure = pressure;
               tick_count    = '0;
               timer_on      = 1'b1;
               seq_step      = CODE_STEP_SETTLE;
            end
         end
         CODE_STEP_SETTLE: begin
            if (tick_count > sample_period) begin
               gap = (pressure >= held_pressure) ? pressure - held_pressure
                                                 : held_pressure - pressure;
               if (gap < settle_band) begin
                  timer_on = 1'b0;
                  seq_step = CODE_STEP_STOP;
                  settles++;
               end else begin
                  held_pressure = pressure;
                  tick_count    = '0;
               end
            end
         end
         CODE_STEP_STOP: begin
            motor_on = 1'b0;
            if (!fb) begin
               seq_phase = CODE_COMPLETE;
               completions++;
            end
         end
         default: ;
      endcase
   endfunction

   // command or tick applied to the sequencer copy
   function automatic void advance_sequencer(input logic [2:0] act, input logic [15:0] pressure,
                                             input logic fb);
      case (act)
         ACT_START:
            if (seq_phase == CODE_IDLE) seq_phase = CODE_EXEC;
         ACT_HOLD:
            if (seq_phase == CODE_EXEC) seq_phase = CODE_HOLDING;
         ACT_STOP:
            if (seq_phase == CODE_EXEC || seq_phase == CODE_RESUMING ||
                seq_phase == CODE_HOLDING || seq_phase == CODE_HELD)
               seq_phase = CODE_STOPPING;
         ACT_RESUME:
            if (seq_phase == CODE_HELD) seq_phase = CODE_RESUMING;
         ACT_RESET:
            if (seq_phase == CODE_STOPPED || seq_phase == CODE_COMPLETE)
               seq_phase = CODE_RESETTING;
         ACT_UPDATE: begin
            // timer counts first and saturates
            if (timer_on && tick_count != TICK_MAX)
               tick_count = tick_count + 16'd1;
            case (seq_phase)
               CODE_EXEC:
                  run_step(pressure, fb);
               CODE_HOLDING, CODE_STOPPING: begin
                  motor_on = 1'b0;
                  if (!fb) begin
                     timer_on = 1'b0;
                     if (seq_phase == CODE_HOLDING) begin
                        seq_phase = CODE_HELD;
                        holds++;
                     end else begin
                        seq_phase = CODE_STOPPED;
                     end
                  end
               end
               CODE_RESUMING, CODE_RESETTING: begin
                  tick_count = '0;
                  timer_on   = 1'b0;
                  seq_step   = CODE_STEP_START;
                  seq_phase  = (seq_phase == CODE_RESUMING) ? CODE_EXEC : CODE_IDLE;
               end
               CODE_COMPLETE:
                  seq_phase = CODE_RESETTING;
               default: ;
            endcase
         end
         default: ;
      endcase
   endfunction

   // watch all three channels at each edge
   always @(posedge clock) begin
      phase_result_type want;
      phase_result_type got;
      if (reset) begin
         sample_period = SAMPLING_TICKS_RST;
         settle_band   = SETTLE_THRESHOLD_RST;
         seq_phase     = CODE_IDLE;
         seq_step      = CODE_STEP_START;
         tick_count    = '0;
         timer_on      = 1'b0;
         held_pressure = '0;
         motor_on      = 1'b0;
         expected_q.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_SAMPLING_TICKS)
               sample_period = csr_data;
            else
               settle_band = csr_data;
         end

         // result transfer against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            got = phase_result_type'(rsp_tdata[6:0]);
            if (expected_q.size() == 0) begin
               note_failure("no result expected", '0, got);
            end else begin
               want = expected_q.pop_front();
               if (got.phase !== want.phase || got.exec_step !== want.exec_step ||
                   got.motor_request !== want.motor_request)
                  note_failure("field", want, got);
            end
         end

         // request transfer: predict its result
         if (req_tvalid && req_tready) begin
            advance_sequencer(req_tuser, req_tdata[15:0], req_tdata[16]);
            want.phase         = seq_phase;
            want.exec_step     = seq_step;
            want.motor_request = motor_on;
            expected_q.push_back(want);
         end
      end
      mismatch_total <= fail_count;
      pending_total  <= expected_q.size();
      result_total   <= rsp_count;
      settle_total   <= settles;
      complete_total <= completions;
      held_total     <= holds;
   end

endmodule

[dv/phase_sequencer_with_settle_detect_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_sequencer_with_settle_detect_top_test
// Drives commands and update ticks into the phase sequencer: a directed walk
// through every phase and command, then batches of start, motor spin-up,
// pressure settling, hold/resume and stop/reset under a range of sampling
// periods and thresholds, with random noise items, random idling on both
// channels and long result stalls. The checker does all comparison.
// ----------------------------------------------------------------------------
module phase_sequencer_with_settle_detect_top_test;
   import phs_pkg::*;

   // action codes the block does not define
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   localparam int IDLE_PCT      = 36;
   localparam int HOLD_CYCLES   = 64;
   localparam int ITEM_TARGET   = 1040;
   localparam int PHASE_ITEMS   = 110;
   localparam int SETTLE_CYCLES = 6;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;    // [15:0] pressure_sample, [16] motor_is_on, rest zero
   logic [2:0]  req_tuser  = ACT_START; // [2:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [3:0] phase, [5:4] exec_step, [6] motor_request, [7] zero
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = REG_SAMPLING_TICKS;
   logic [15:0] csr_data   = '0;

   logic        idle_on = 1'b1;
   int          items_sent = 0;
   int          settings_used = 0;
   int          cur_threshold = SETTLE_THRESHOLD_RST;

   int mismatch_total, pending_total, result_total;
   int settle_total, complete_total, held_total;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   phase_sequencer_with_settle_detect_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   phase_sequencer_with_settle_detect_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_total (mismatch_total),
      .pending_total  (pending_total),
      .result_total   (result_total),
      .settle_total   (settle_total),
      .complete_total (complete_total),
      .held_total     (held_total)
   );

   // one request transfer, with idle cycles in front drawn one at a time
   task automatic send_item(input logic [2:0] act, input logic [15:0] pressure, input logic fb);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'd0, fb, pressure};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // stop offering and wait until every result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (result_total < items_sent);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers in one burst, order chosen at random
   task automatic program_settings(input logic [15:0] period, input logic [15:0] band);
      logic first;
      first = 1'($urandom_range(1));
      csr_valid <= 1'b1;
      csr_index <= first;
      csr_data  <= (first == REG_SAMPLING_TICKS) ? period : band;
      do @(posedge clock); while (!csr_ready);
      csr_index <= ~first;
      csr_data  <= (first == REG_SAMPLING_TICKS) ? band : period;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_threshold = band;
      settings_used++;
   endtask

   // pressure close to the held one, mostly inside the settle band
   function automatic logic [15:0] near_pressure(input logic [15:0] base);
      int offset;
      offset = int'($urandom_range(0, 2 * cur_threshold + 1)) - cur_threshold;
      return 16'(int'(base) + offset);
   endfunction

   // anything at all, codes the block ignores included
   task automatic send_noise();
      send_item(3'($urandom_range(0, 7)), 16'($urandom), 1'($urandom_range(1)));
   endtask

   // one batch: start, spin-up, settling with interruptions, then wind-down
   task automatic run_batch();
      logic [15:0] base;
      int          n;
      base = 16'($urandom);
      send_item(ACT_START, 16'($urandom), 1'($urandom_range(1)));
      repeat ($urandom_range(0, 2)) send_item(ACT_UPDATE, 16'($urandom), 1'b0);
      send_item(ACT_UPDATE, base, 1'b1);

      // settling ticks
      n = $urandom_range(2, 14);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 10) begin
            send_noise();
         end else if ($urandom_range(99) < 6) begin
            // hold until the motor stops, then resume or give up
            send_item(ACT_HOLD, 16'($urandom), 1'b1);
            send_item(ACT_UPDATE, 16'($urandom), 1'b1);
            send_item(ACT_UPDATE, 16'($urandom), 1'b0);
            if ($urandom_range(1)) begin
               send_item(ACT_RESUME, 16'($urandom), 1'b0);
               send_item(ACT_UPDATE, 16'($urandom), 1'b0);
               send_item(ACT_UPDATE, base, 1'b1);
            end else begin
               send_item(ACT_STOP, 16'($urandom), 1'b0);
            end
         end else begin
            send_item(ACT_UPDATE, ($urandom_range(99) < 75) ? near_pressure(base) : 16'($urandom),
                      1'b1);
         end
      end

      // wind-down, natural or forced back to idle
      if ($urandom_range(1)) begin
         send_item(ACT_UPDATE, near_pressure(base), 1'b1);
         send_item(ACT_UPDATE, 16'($urandom), 1'b0);
         send_item(ACT_UPDATE, 16'($urandom), 1'($urandom_range(1)));
         send_item(ACT_UPDATE, 16'($urandom), 1'($urandom_range(1)));
      end else begin
         send_item(ACT_STOP, 16'($urandom), 1'($urandom_range(1)));
         send_item(ACT_UPDATE, 16'($urandom), 1'b0);
         send_item(ACT_RESET, 16'($urandom), 1'($urandom_range(1)));
         send_item(ACT_UPDATE, 16'($urandom), 1'($urandom_range(1)));
      end
   endtask

   // result side: random stalls plus long hold-offs part way through
   initial begin : rsp_side
      int hold_left;
      int next_hold_at;
      hold_left    = 0;
      next_hold_at = 400;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && next_hold_at != 0 && result_total >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = (next_hold_at < 900) ? 900 : 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // run limit
   initial begin : watchdog
      #2_000_000;
      $display("[phase_sequencer_with_settle_detect_top] ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] period_tbl [7];
      logic [15:0] band_tbl   [7];
      logic [15:0] period;
      logic [15:0] band;
      int          phase_idx;
      int          phase_end;

      period_tbl = '{16'd0, 16'd65535, 16'd1, 16'd2, 16'd0, 16'd3, 16'd1000};
      band_tbl   = '{16'd0, 16'd65535, 16'd300, 16'd2000, 16'd65535, 16'd50, 16'd100};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk: zero period, widest band
      program_settings(16'd0, 16'hFFFF);
      send_item(ACT_SPARE_6, 16'h0000, 1'b0);
      send_item(ACT_HOLD,    16'hFFFF, 1'b1);
      send_item(ACT_RESUME,  16'h0000, 1'b1);
      send_item(ACT_STOP,    16'hFFFF, 1'b0);
      send_item(ACT_RESET,   16'h0000, 1'b0);
      send_item(ACT_UPDATE,  16'hFFFF, 1'b1);
      send_item(ACT_START,   16'h0000, 1'b0);
      send_item(ACT_UPDATE,  16'h0000, 1'b0);
      send_item(ACT_UPDATE,  16'hFFFF, 1'b1);
      send_item(ACT_UPDATE,  16'h0000, 1'b1);   // full-scale jump, not settled
      send_item(ACT_HOLD,    16'h1234, 1'b1);
      send_item(ACT_UPDATE,  16'h1234, 1'b1);   // motor still turning
      send_item(ACT_UPDATE,  16'h1234, 1'b0);
      send_item(ACT_SPARE_7, 16'hA5A5, 1'b1);
      send_item(ACT_RESUME,  16'h5A5A, 1'b0);
      send_item(ACT_UPDATE,  16'h5A5A, 1'b0);
      send_item(ACT_UPDATE,  16'h8000, 1'b1);
      send_item(ACT_UPDATE,  16'h8001, 1'b1);   // settles
      send_item(ACT_UPDATE,  16'h8001, 1'b1);
      send_item(ACT_UPDATE,  16'h8001, 1'b0);   // complete
      send_item(ACT_RESET,   16'h0000, 1'b0);
      send_item(ACT_UPDATE,  16'h0000, 1'b0);
      send_item(ACT_START,   16'h0000, 1'b0);
      send_item(ACT_STOP,    16'h0000, 1'b0);
      send_item(ACT_UPDATE,  16'h0000, 1'b0);
      send_item(ACT_RESET,   16'h0000, 1'b1);
      send_item(ACT_UPDATE,  16'h0000, 1'b1);
      drain_results();

      // random batches, one setting per phase
      phase_idx = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase_idx < 7) begin
            period = period_tbl[phase_idx];
            band   = band_tbl[phase_idx];
         end else begin
            period = 16'($urandom_range(0, 6));
            band   = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(0, 400));
         end
         program_settings(period, band);
         idle_on <= (phase_idx != 2);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) run_batch();
         drain_results();
         phase_idx++;
      end

      // verdict
      $display("covered %0d requests under %0d register settings: %0d settles, %0d completions, %0d holds",
               items_sent, settings_used, settle_total, complete_total, held_total);
      $display("%0d results checked, %0d mismatches", result_total, mismatch_total);
      if (mismatch_total == 0 && pending_total == 0) begin
         $display("[phase_sequencer_with_settle_detect_top] OK");
      end else begin
         $display("[phase_sequencer_with_settle_detect_top] ERROR");
      end
      $finish;
   end

endmodule

[files.f]
src/phs_pkg.sv
src/phs_in_stage.sv
src/phs_engine.sv
src/phase_sequencer_with_settle_detect_top.sv
dv/phase_sequencer_with_settle_detect_checker.sv
dv/phase_sequencer_with_settle_detect_top_test.sv
